// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at each rising clk edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cond at one edge implies prop at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: design/gdsc_pkg.sv
// ----------------------------------------------------------------------------
// gdsc_pkg
// Types and constants of the Gregorian date shift and compare block.
// ----------------------------------------------------------------------------
package gdsc_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;

    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DOM_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DOM_W-1:0]   DAY_LAST  = 5'd31;
    localparam logic [DOM_W-1:0]   DAY_LEAP_FEB = 5'd29;

    // floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT, exact for 14-bit y
    localparam int                 DIV100_MUL_W = 13;
    localparam logic [12:0]        DIV100_MUL   = 13'd5243;
    localparam int                 DIV100_SHIFT = 19;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FWD,
        ST_BWD,
        ST_DONE
    } t_state;

    function automatic logic [DOM_W-1:0] month_base(input logic [MONTH_W-1:0] m);
        logic [DOM_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// File: design/gdsc_month_len.sv
// ----------------------------------------------------------------------------
// gdsc_month_len
// Shared month length unit: days in a month with the 4/100/400 leap rule.
// Returns zero for a month code outside 1 to 12.
// ----------------------------------------------------------------------------
module gdsc_month_len import gdsc_pkg::*; (
    input  logic [YEAR_W-1:0]  i_year,
    input  logic [MONTH_W-1:0] i_month,
    output logic [DOM_W-1:0]   o_length
);

    localparam int PROD_W = YEAR_W + DIV100_MUL_W;
    localparam int QUO_W  = PROD_W - DIV100_SHIFT;

    logic [PROD_W-1:0] prod;
    logic [QUO_W-1:0]  quo;
    logic [YEAR_W-1:0] hundreds;
    logic              century;
    logic              leap;

    assign prod     = PROD_W'(i_year) * PROD_W'(DIV100_MUL);
    assign quo      = prod[PROD_W-1:DIV100_SHIFT];
    assign hundreds = YEAR_W'({quo, 6'b0}) + YEAR_W'({quo, 5'b0}) + YEAR_W'({quo, 2'b0});
    assign century  = (hundreds == i_year);
    assign leap     = (i_year[1:0] == 2'b00) && (!century || (quo[1:0] == 2'b00));
    assign o_length = ((i_month == MONTH_FEB) && leap) ? DAY_LEAP_FEB : month_base(i_month);

endmodule

// File: design/gregorian_date_shift_compare.sv
// ----------------------------------------------------------------------------
// gregorian_date_shift_compare
// Adds a signed day offset to a Gregorian date one month per cycle and
// compares the date against a second date.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_stall carries a date, a day offset and a second
// date; a transfer happens at an edge with i_valid high and o_stall low.
// Output channel o_valid/i_stall carries the shifted date, the less and
// equal flags, and the invalid-date and saturation flags.
// One item is worked at a time: o_stall is high from the transfer until the
// result is loaded into the output register. After the transfer the item
// passes the check state, then forward or backward month steps, one per
// month boundary crossed (about 2200 for an offset of 65535 days), then
// the done state. An invalid date goes from the check state straight to
// the done state.
// Each month step is one pass through the month length unit.
// The output register holds a result while i_stall is high and the next
// item is taken meanwhile; its result waits in the done state until the
// output register is free.
// A synchronous low i_rst_n returns to idle with no result pending.
// An invalid date passes through with o_date_invalid set; a shift past
// 9999-12-31 or before 0001-01-01 saturates with o_out_of_range set.
// ----------------------------------------------------------------------------
module gregorian_date_shift_compare import gdsc_pkg::*; #(
    parameter int OFFSET_WIDTH = 17
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [YEAR_W-1:0]              i_year,
    input  logic [MONTH_W-1:0]             i_month,
    input  logic [DOM_W-1:0]               i_day_of_month,
    input  logic signed [OFFSET_WIDTH-1:0] i_offset_days,
    input  logic [YEAR_W-1:0]              i_other_year,
    input  logic [MONTH_W-1:0]             i_other_month,
    input  logic [DOM_W-1:0]               i_other_day,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [YEAR_W-1:0]              o_result_year,
    output logic [MONTH_W-1:0]             o_result_month,
    output logic [DOM_W-1:0]               o_result_day,
    output logic                           o_is_less,
    output logic                           o_is_equal,
    output logic                           o_date_invalid,
    output logic                           o_out_of_range
);

    localparam int DW = OFFSET_WIDTH + 1;

    t_state                r_state, n_state;
    logic [YEAR_W-1:0]     r_year, n_year;
    logic [MONTH_W-1:0]    r_month, n_month;
    logic [DOM_W-1:0]      r_dom, n_dom;
    logic signed [DW-1:0]  r_day, n_day;
    logic                  r_less, n_less;
    logic                  r_equal, n_equal;
    logic                  r_invalid, n_invalid;
    logic                  r_oor, n_oor;
    logic                  r_out_valid, n_out_valid;
    logic [YEAR_W-1:0]     r_out_year, n_out_year;
    logic [MONTH_W-1:0]    r_out_month, n_out_month;
    logic [DOM_W-1:0]      r_out_day, n_out_day;
    logic                  r_out_less, n_out_less;
    logic                  r_out_equal, n_out_equal;
    logic                  r_out_invalid, n_out_invalid;
    logic                  r_out_oor, n_out_oor;

    logic                  in_xfer;
    logic                  out_free;
    logic [MONTH_W-1:0]    prev_month;
    logic [YEAR_W-1:0]     prev_year;
    logic [YEAR_W-1:0]     unit_year;
    logic [MONTH_W-1:0]    unit_month;
    logic [DOM_W-1:0]      mlen;
    logic signed [DW-1:0]  mlen_s;
    logic                  date_ok;
    logic                  fwd_step;
    logic                  fwd_sat;
    logic                  bwd_step;
    logic                  bwd_sat;
    logic                  eq_year;
    logic                  eq_month;

    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    assign prev_month = (r_month == MONTH_JAN) ? MONTH_DEC : r_month - MONTH_JAN;
    assign prev_year  = (r_month == MONTH_JAN) ? r_year - YEAR_MIN : r_year;
    assign unit_year  = (r_state == ST_BWD) ? prev_year : r_year;
    assign unit_month = (r_state == ST_BWD) ? prev_month : r_month;

    gdsc_month_len u_month_len (
        .i_year   (unit_year),
        .i_month  (unit_month),
        .o_length (mlen)
    );

    assign mlen_s   = $signed({{(DW-DOM_W){1'b0}}, mlen});
    assign date_ok  = (r_year >= YEAR_MIN) && (r_year <= YEAR_MAX) && (mlen != '0)
                      && (r_dom != '0) && (r_dom <= mlen);
    assign fwd_step = (r_day > mlen_s);
    assign fwd_sat  = fwd_step && (r_month == MONTH_DEC) && (r_year == YEAR_MAX);
    assign bwd_step = (r_day <= 0);
    assign bwd_sat  = bwd_step && (r_month == MONTH_JAN) && (r_year == YEAR_MIN);

    assign eq_year  = (i_year == i_other_year);
    assign eq_month = (i_month == i_other_month);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!date_ok) begin
                    n_state = ST_DONE;
                end else if (r_day > 0) begin
                    n_state = ST_FWD;
                end else begin
                    n_state = ST_BWD;
                end
            end
            ST_FWD: begin
                if (!fwd_step || fwd_sat) begin
                    n_state = ST_DONE;
                end
            end
            ST_BWD: begin
                if (!bwd_step || bwd_sat) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_year        = r_year;
        n_month       = r_month;
        n_dom         = r_dom;
        n_day         = r_day;
        n_less        = r_less;
        n_equal       = r_equal;
        n_invalid     = r_invalid;
        n_oor         = r_oor;
        n_out_valid   = r_out_valid && i_stall;
        n_out_year    = r_out_year;
        n_out_month   = r_out_month;
        n_out_day     = r_out_day;
        n_out_less    = r_out_less;
        n_out_equal   = r_out_equal;
        n_out_invalid = r_out_invalid;
        n_out_oor     = r_out_oor;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_year    = i_year;
                    n_month   = i_month;
                    n_dom     = i_day_of_month;
                    n_day     = $signed({{(DW-DOM_W){1'b0}}, i_day_of_month})
                                + $signed({i_offset_days[OFFSET_WIDTH-1], i_offset_days});
                    n_less    = (i_year < i_other_year)
                                || (eq_year && (i_month < i_other_month))
                                || (eq_year && eq_month && (i_day_of_month < i_other_day));
                    n_equal   = eq_year && eq_month && (i_day_of_month == i_other_day);
                    n_invalid = 1'b0;
                    n_oor     = 1'b0;
                end
            end
            ST_CHECK: begin
                n_invalid = !date_ok;
            end
            ST_FWD: begin
                if (fwd_sat) begin
                    n_year  = YEAR_MAX;
                    n_month = MONTH_DEC;
                    n_day   = $signed({{(DW-DOM_W){1'b0}}, DAY_LAST});
                    n_oor   = 1'b1;
                end else if (fwd_step) begin
                    n_day = r_day - mlen_s;
                    if (r_month == MONTH_DEC) begin
                        n_month = MONTH_JAN;
                        n_year  = r_year + YEAR_MIN;
                    end else begin
                        n_month = r_month + MONTH_JAN;
                    end
                end
            end
            ST_BWD: begin
                if (bwd_sat) begin
                    n_year  = YEAR_MIN;
                    n_month = MONTH_JAN;
                    n_day   = $signed({{(DW-DOM_W){1'b0}}, DAY_FIRST});
                    n_oor   = 1'b1;
                end else if (bwd_step) begin
                    n_year  = prev_year;
                    n_month = prev_month;
                    n_day   = r_day + mlen_s;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_year    = r_year;
                    n_out_month   = r_month;
                    n_out_day     = r_invalid ? r_dom : r_day[DOM_W-1:0];
                    n_out_less    = r_less;
                    n_out_equal   = r_equal;
                    n_out_invalid = r_invalid;
                    n_out_oor     = r_oor;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_year        <= n_year;
        r_month       <= n_month;
        r_dom         <= n_dom;
        r_day         <= n_day;
        r_less        <= n_less;
        r_equal       <= n_equal;
        r_invalid     <= n_invalid;
        r_oor         <= n_oor;
        r_out_year    <= n_out_year;
        r_out_month   <= n_out_month;
        r_out_day     <= n_out_day;
        r_out_less    <= n_out_less;
        r_out_equal   <= n_out_equal;
        r_out_invalid <= n_out_invalid;
        r_out_oor     <= n_out_oor;
    end

    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_result_year  = r_out_year;
    assign o_result_month = r_out_month;
    assign o_result_day   = r_out_day;
    assign o_is_less      = r_out_less;
    assign o_is_equal     = r_out_equal;
    assign o_date_invalid = r_out_invalid;
    assign o_out_of_range = r_out_oor;

endmodule

// File: design/gdsc_checker.sv
// ----------------------------------------------------------------------------
// gdsc_checker
// Port-level checks of the date shift and compare block, bound to its top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gdsc_checker import gdsc_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input logic [YEAR_W-1:0]   o_result_year,
    input logic [MONTH_W-1:0]  o_result_month,
    input logic [DOM_W-1:0]    o_result_day,
    input logic                o_is_less,
    input logic                o_is_equal,
    input logic                o_date_invalid,
    input logic                o_out_of_range
);

    logic held;
    logic cmp_both;
    logic flag_both;
    logic range_ok;
    logic range_fail;
    logic sat_ok;
    logic sat_fail;

    assign held       = o_valid && i_stall;
    assign cmp_both   = o_valid && o_is_less && o_is_equal;
    assign flag_both  = o_valid && o_date_invalid && o_out_of_range;
    assign range_ok   = (o_result_year >= YEAR_MIN) && (o_result_year <= YEAR_MAX)
                        && (o_result_month >= MONTH_JAN) && (o_result_month <= MONTH_DEC)
                        && (o_result_day >= DAY_FIRST);
    assign range_fail = o_valid && !o_date_invalid && !range_ok;
    assign sat_ok     = ((o_result_year == YEAR_MAX) && (o_result_month == MONTH_DEC)
                         && (o_result_day == DAY_LAST))
                        || ((o_result_year == YEAR_MIN) && (o_result_month == MONTH_JAN)
                         && (o_result_day == DAY_FIRST));
    assign sat_fail   = o_valid && o_out_of_range && !sat_ok;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, held, o_valid, "result dropped while stalled")

    `ASSERT_CLK(a_less_equal_excl, i_clk, i_rst_n, !cmp_both, "less and equal both set")

    `ASSERT_CLK(a_flags_excl, i_clk, i_rst_n, !flag_both, "invalid and saturated both set")

    `ASSERT_CLK(a_valid_range, i_clk, i_rst_n, !range_fail, "shifted date out of range")

    `ASSERT_CLK(a_sat_value, i_clk, i_rst_n, !sat_fail, "saturated date wrong")

endmodule

bind gregorian_date_shift_compare gdsc_checker u_gdsc_checker (.*);

// File: sim/tb_gregorian_date_shift_compare.sv
// ----------------------------------------------------------------------------
// tb_gregorian_date_shift_compare
// Self-checking bench for the date shift and compare block. A directed set
// hits leap rules, malformed dates, saturation at both ends and each branch
// of the compare. A random set follows: mostly well-formed dates with short
// offsets, some with the widest offsets, and raw noise on every field. Each
// transfer is predicted in the bench and checked in order at the output.
// ----------------------------------------------------------------------------
module tb_gregorian_date_shift_compare import gdsc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OFFSET_WIDTH   = 17;
    localparam int HALF_PERIOD    = 1;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_JOBS    = 236;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 12000;

    typedef struct {
        bit [YEAR_W-1:0]               year;
        bit [MONTH_W-1:0]              month;
        bit [DOM_W-1:0]                dom;
        bit signed [OFFSET_WIDTH-1:0]  offset;
        bit [YEAR_W-1:0]               other_year;
        bit [MONTH_W-1:0]              other_month;
        bit [DOM_W-1:0]                other_day;
        bit                            drain;
    } t_date_job;

    typedef struct {
        bit [YEAR_W-1:0]  year;
        bit [MONTH_W-1:0] month;
        bit [DOM_W-1:0]   day;
        bit               less;
        bit               equal;
        bit               invalid;
        bit               saturated;
    } t_shifted_date;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_valid        = 1'b0;
    logic                          o_stall;
    logic [YEAR_W-1:0]             i_year         = '0;
    logic [MONTH_W-1:0]            i_month        = '0;
    logic [DOM_W-1:0]              i_day_of_month = '0;
    logic signed [OFFSET_WIDTH-1:0] i_offset_days = '0;
    logic [YEAR_W-1:0]             i_other_year   = '0;
    logic [MONTH_W-1:0]            i_other_month  = '0;
    logic [DOM_W-1:0]              i_other_day    = '0;
    logic                          o_valid;
    logic                          i_stall        = 1'b0;
    logic [YEAR_W-1:0]             o_result_year;
    logic [MONTH_W-1:0]            o_result_month;
    logic [DOM_W-1:0]              o_result_day;
    logic                          o_is_less;
    logic                          o_is_equal;
    logic                          o_date_invalid;
    logic                          o_out_of_range;

    t_date_job     shift_jobs[$];
    t_shifted_date expected_dates[$];
    t_date_job     cur_job;
    int            job_count     = 0;
    int            dates_sent    = 0;
    int            dates_checked = 0;
    int            mismatches    = 0;
    int            quiet_cycles  = 0;

    gregorian_date_shift_compare #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_year         (i_year),
        .i_month        (i_month),
        .i_day_of_month (i_day_of_month),
        .i_offset_days  (i_offset_days),
        .i_other_year   (i_other_year),
        .i_other_month  (i_other_month),
        .i_other_day    (i_other_day),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_year  (o_result_year),
        .o_result_month (o_result_month),
        .o_result_day   (o_result_day),
        .o_is_less      (o_is_less),
        .o_is_equal     (o_is_equal),
        .o_date_invalid (o_date_invalid),
        .o_out_of_range (o_out_of_range)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic int days_in_month(int y, int m);
        if (m < MONTH_JAN || m > MONTH_DEC) return 0;
        if (m == MONTH_FEB)
            return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        return 31;
    endfunction

    function automatic t_shifted_date shift_and_compare(t_date_job j);
        t_shifted_date r;
        int y, m, d;
        y = j.year;
        m = j.month;
        d = j.dom;
        r.year      = j.year;
        r.month     = j.month;
        r.day       = j.dom;
        r.invalid   = 1'b0;
        r.saturated = 1'b0;
        if (y < YEAR_MIN || y > YEAR_MAX || m < MONTH_JAN || m > MONTH_DEC ||
            d < DAY_FIRST || d > days_in_month(y, m)) begin
            r.invalid = 1'b1;
        end else begin
            d = d + int'(j.offset);
            while (!r.saturated && d > days_in_month(y, m)) begin
                d -= days_in_month(y, m);
                m++;
                if (m > MONTH_DEC) begin
                    m = MONTH_JAN;
                    y++;
                    if (y > YEAR_MAX) begin
                        r.saturated = 1'b1;
                        y = YEAR_MAX;
                        m = MONTH_DEC;
                        d = DAY_LAST;
                    end
                end
            end
            while (!r.saturated && d <= 0) begin
                m--;
                if (m == 0) begin
                    m = MONTH_DEC;
                    y--;
                    if (y < YEAR_MIN) begin
                        r.saturated = 1'b1;
                        y = YEAR_MIN;
                        m = MONTH_JAN;
                        d = DAY_FIRST;
                    end
                end
                if (!r.saturated) d += days_in_month(y, m);
            end
            r.year  = YEAR_W'(y);
            r.month = MONTH_W'(m);
            r.day   = DOM_W'(d);
        end
        r.less = (j.year < j.other_year) ||
                 (j.year == j.other_year && j.month < j.other_month) ||
                 (j.year == j.other_year && j.month == j.other_month &&
                  j.dom < j.other_day);
        r.equal = (j.year == j.other_year) && (j.month == j.other_month) &&
                  (j.dom == j.other_day);
        return r;
    endfunction

    function automatic t_date_job make_job(int y, int m, int d, int off,
                                           int oy, int om, int od);
        t_date_job j;
        j.year        = YEAR_W'(y);
        j.month       = MONTH_W'(m);
        j.dom         = DOM_W'(d);
        j.offset      = OFFSET_WIDTH'(off);
        j.other_year  = YEAR_W'(oy);
        j.other_month = MONTH_W'(om);
        j.other_day   = DOM_W'(od);
        j.drain       = 1'b0;
        return j;
    endfunction

    function automatic t_date_job rand_job();
        t_date_job j;
        int pick, y, m, off;
        pick = $urandom_range(99);
        if (pick < 25) begin
            j = make_job($urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
        end else begin
            y = ($urandom_range(9) == 0) ?
                ($urandom_range(1) ? $urandom_range(3, 1) : $urandom_range(9999, 9997)) :
                $urandom_range(9999, 1);
            m = $urandom_range(12, 1);
            pick = $urandom_range(99);
            if (pick < 60)      off = int'($urandom_range(800)) - 400;
            else if (pick < 90) off = int'($urandom_range(10000)) - 5000;
            else                off = $urandom;
            j = make_job(y, m, $urandom_range(days_in_month(y, m), 1), off, 0, 0, 0);
            pick = $urandom_range(99);
            if (pick < 55) begin
                j.other_year  = j.year;
                j.other_month = j.month;
                j.other_day   = j.dom;
                if (pick >= 30) begin
                    case ($urandom_range(2))
                        0: j.other_year  = YEAR_W'(int'(j.other_year)
                                           + ($urandom_range(1) ? 1 : -1));
                        1: j.other_month = MONTH_W'(int'(j.other_month)
                                           + ($urandom_range(1) ? 1 : -1));
                        default: j.other_day = DOM_W'(int'(j.other_day)
                                               + ($urandom_range(1) ? 1 : -1));
                    endcase
                end
            end else begin
                j.other_year  = YEAR_W'($urandom);
                j.other_month = MONTH_W'($urandom);
                j.other_day   = DOM_W'($urandom);
            end
        end
        j.drain = ($urandom_range(99) < 3);
        return j;
    endfunction

    function automatic int idle_pct(int sent, bit rx_side);
        if (sent < job_count / 3) return rx_side ? 60 : 14;
        if (sent < 2 * job_count / 3) return rx_side ? 14 : 60;
        return 0;
    endfunction

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : drive_jobs
        bit took;
        took = i_valid && !o_stall;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (took) begin
                expected_dates.push_back(shift_and_compare(cur_job));
                dates_sent <= dates_sent + 1;
            end
            if (!i_valid || took) begin
                if (shift_jobs.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (shift_jobs[0].drain &&
                             dates_sent + int'(took) != dates_checked) begin
                    i_valid <= 1'b0;
                end else if ($urandom_range(99) < idle_pct(dates_sent, 1'b0)) begin
                    i_valid <= 1'b0;
                end else begin
                    cur_job = shift_jobs.pop_front();
                    i_valid        <= 1'b1;
                    i_year         <= cur_job.year;
                    i_month        <= cur_job.month;
                    i_day_of_month <= cur_job.dom;
                    i_offset_days  <= cur_job.offset;
                    i_other_year   <= cur_job.other_year;
                    i_other_month  <= cur_job.other_month;
                    i_other_day    <= cur_job.other_day;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_shifted_date want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < idle_pct(dates_sent, 1'b1));
            if (o_valid && !i_stall) begin
                if (expected_dates.size() == 0) begin
                    $display("%0t: result with nothing pending, expected none actual %0d-%0d-%0d",
                             $time, o_result_year, o_result_month, o_result_day);
                    mismatches++;
                end else begin
                    want = expected_dates.pop_front();
                    check_field("result_year", want.year, o_result_year);
                    check_field("result_month", want.month, o_result_month);
                    check_field("result_day", want.day, o_result_day);
                    check_field("is_less", want.less, o_is_less);
                    check_field("is_equal", want.equal, o_is_equal);
                    check_field("date_invalid", want.invalid, o_date_invalid);
                    check_field("out_of_range", want.saturated, o_out_of_range);
                    dates_checked <= dates_checked + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_gregorian_date_shift_compare failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : run_test
        t_date_job j;
        shift_jobs.push_back(make_job(2024, 2, 29, 0, 2024, 2, 29));
        shift_jobs.push_back(make_job(2023, 2, 29, 5, 2023, 3, 1));
        shift_jobs.push_back(make_job(1900, 2, 29, 1, 1900, 2, 28));
        shift_jobs.push_back(make_job(2000, 2, 29, 1, 2000, 2, 29));
        shift_jobs.push_back(make_job(2024, 3, 1, -1, 2024, 3, 2));
        shift_jobs.push_back(make_job(2023, 12, 31, 1, 2024, 1, 1));
        shift_jobs.push_back(make_job(0, 1, 1, 10, 0, 1, 1));
        shift_jobs.push_back(make_job(16383, 15, 31, -65536, 16383, 15, 31));
        shift_jobs.push_back(make_job(2024, 0, 10, 3, 2024, 1, 10));
        shift_jobs.push_back(make_job(2024, 13, 10, 3, 2024, 12, 10));
        shift_jobs.push_back(make_job(2024, 4, 0, 3, 2024, 4, 1));
        shift_jobs.push_back(make_job(2024, 4, 31, 3, 2024, 4, 30));
        j = make_job(9999, 12, 31, 1, 9999, 12, 31);
        j.drain = 1'b1;
        shift_jobs.push_back(j);
        shift_jobs.push_back(make_job(1, 1, 1, -1, 1, 1, 1));
        shift_jobs.push_back(make_job(9999, 12, 31, 65535, 1, 1, 1));
        shift_jobs.push_back(make_job(1, 1, 1, -65536, 9999, 12, 31));
        shift_jobs.push_back(make_job(2000, 1, 1, 65535, 2000, 1, 2));
        shift_jobs.push_back(make_job(5000, 6, 15, -65536, 5000, 7, 14));
        shift_jobs.push_back(make_job(8, 3, 1, -65536, 8, 2, 28));
        shift_jobs.push_back(make_job(2024, 5, 3, 0, 2024, 4, 9));
        shift_jobs.push_back(make_job(2024, 4, 9, 0, 2024, 5, 3));
        shift_jobs.push_back(make_job(2023, 12, 31, 0, 2024, 1, 1));
        shift_jobs.push_back(make_job(2024, 6, 10, 0, 2024, 6, 11));
        shift_jobs.push_back(make_job(2024, 6, 11, 0, 2024, 6, 10));
        shift_jobs.push_back(make_job(100, 1, 1, 0, 0, 0, 0));
        for (int k = 0; k < RANDOM_JOBS; k++) begin
            j = rand_job();
            if (k == 0) j.drain = 1'b1;
            shift_jobs.push_back(j);
        end
        job_count = shift_jobs.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (dates_sent != job_count || dates_checked != dates_sent);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb_gregorian_date_shift_compare passed");
        else
            $display("tb_gregorian_date_shift_compare failed");
        $finish;
    end

endmodule
